// ===== rtl/cbod_pkg.sv =====
// ----------------------------------------------------------------------------
// cbod_pkg
// Types and constants shared by the byte-order detector controller, datapath,
// top level and checker.
// ----------------------------------------------------------------------------
package cbod_pkg;

   // Field widths fixed by the frame format, and the vote total width
   localparam int unsigned IDENT_W = 29;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned TOTAL_W = 24;

   // Result status codes
   localparam logic [2:0] STATUS_IGNORED = 3'd0;
   localparam logic [2:0] STATUS_FIRST = 3'd1;
   localparam logic [2:0] STATUS_COMPARED = 3'd2;
   localparam logic [2:0] STATUS_FULL = 3'd3;
   localparam logic [2:0] STATUS_CLEARED = 3'd4;

   // Vote and order codes share one encoding
   localparam logic [1:0] ORDER_NONE = 2'd0;
   localparam logic [1:0] ORDER_LITTLE = 2'd1;
   localparam logic [1:0] ORDER_BIG = 2'd2;

   // Request function codes
   localparam logic FUNC_OBSERVE = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // Control register indexes
   localparam logic CSR_AUTO_DETECT = 1'b0;
   localparam logic CSR_LEAD_THRESHOLD = 1'b1;

   // Register reset values and frame rules
   localparam logic AUTO_DETECT_RESET = 1'b1;
   localparam logic [7:0] LEAD_THRESHOLD_RESET = 8'd12;
   localparam logic [3:0] MIN_LENGTH = 4'd2;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef struct packed {
      logic                func;
      logic [IDENT_W-1:0]  can_id;
      logic                is_remote;
      logic [3:0]          length_code;
      logic [7:0]          first_byte;
      logic [7:0]          second_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [1:0] vote;
      logic [1:0] detected_order;
      logic       newly_detected;
   } rsp_type;

   // One table entry: identifier and last word, byte 0 in the upper half
   typedef struct packed {
      logic [IDENT_W-1:0] ident;
      logic [WORD_W-1:0]  word;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;
      logic       clear;
      logic       scan_init;
      logic       scan_step;
      logic       take_hit;
      logic       claim;
      logic       diff;
      logic       vote;
      logic       decide;
      logic       respond;
      logic [2:0] status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_clear;
      logic ignore;
      logic hit;
      logic scan_done;
      logic full;
   } stat_type;

endpackage

// ===== rtl/can_byte_order_detector.sv =====
// A clear or ignored transaction is answered from the dispatch state via the
// result register; an observed frame first walks the filled table entries.
// One transaction is taken at a time; the table walk reads one entry per cycle
// through the memory read port.
// Reset empties the table, zeroes the vote totals and order, and loads
// auto_detect 1 and lead_threshold 12. Results carry no back-pressure.
// ----------------------------------------------------------------------------
// can_byte_order_detector
// Detects the byte order of CAN payload words by voting on which reading of
// the first two bytes changes least between frames of the same identifier.
// ----------------------------------------------------------------------------
module can_byte_order_detector import cbod_pkg::*; #(
   parameter int unsigned TABLE_ENTRIES = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   cbod_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   cbod_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/cbod_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbod_ctrl
// Sequencer: dispatches each transaction, walks the table for observed frames,
// compares and votes on a match, decides unless full, and issues the result.
// ----------------------------------------------------------------------------
module cbod_ctrl import cbod_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DISPATCH = 6'b000010,
      ST_SCAN     = 6'b000100,
      ST_DIFF     = 6'b001000,
      ST_VOTE     = 6'b010000,
      ST_DECIDE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      matched_ff, matched_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      matched_in = matched_ff;
      cmd = '0;
      cmd.status = STATUS_IGNORED;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.is_clear) begin
               cmd.clear = 1'b1;
               cmd.respond = 1'b1;
               cmd.status = STATUS_CLEARED;
               state_in = ST_IDLE;
            end else if (stat.ignore) begin
               cmd.respond = 1'b1;
               cmd.status = STATUS_IGNORED;
               state_in = ST_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               matched_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.hit) begin
               cmd.take_hit = 1'b1;
               matched_in = 1'b1;
               state_in = ST_DIFF;
            end else if (stat.scan_done) begin
               if (stat.full) begin
                  cmd.respond = 1'b1;
                  cmd.status = STATUS_FULL;
                  state_in = ST_IDLE;
               end else begin
                  cmd.claim = 1'b1;
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_VOTE;
         end
         ST_VOTE: begin
            cmd.vote = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            cmd.respond = 1'b1;
            cmd.status = matched_ff ? STATUS_COMPARED : STATUS_FIRST;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         matched_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         matched_ff <= matched_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/cbod_datapath.sv =====
// ----------------------------------------------------------------------------
// cbod_datapath
// Identifier table memory with its fill count and scan pointer, the change
// comparison, vote totals, order decision, control registers and result
// register.
// ----------------------------------------------------------------------------
module cbod_datapath import cbod_pkg::*; #(
   parameter int unsigned TABLE_ENTRIES = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  logic       csr_valid,
   input  logic       csr_index,
   input  logic [7:0] csr_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

   function automatic logic [WORD_W-1:0] abs_diff(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
      return {w[7:0], w[15:8]};
   endfunction

   entry_type         mem [TABLE_ENTRIES];

   req_type           req_ff, req_in;
   logic              auto_detect_ff, auto_detect_in;
   logic [7:0]        threshold_ff, threshold_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   entry_type         rd_data_ff;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [WORD_W-1:0] old_word_ff, old_word_in;
   logic [WORD_W-1:0] be_diff_ff, be_diff_in;
   logic [WORD_W-1:0] le_diff_ff, le_diff_in;
   logic [1:0]        vote_ff, vote_in;
   logic [TOTAL_W-1:0] little_ff, little_in;
   logic [TOTAL_W-1:0] big_ff, big_in;
   logic [1:0]        order_ff, order_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [WORD_W-1:0] new_word;
   logic [TOTAL_W:0]  le_lead;
   logic [TOTAL_W:0]  be_lead;
   logic [1:0]        order_dec;
   logic              fresh;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_entry;

   assign new_word = {req_ff.first_byte, req_ff.second_byte};

   // Status towards the controller
   assign stat.is_clear = (req_ff.func == FUNC_CLEAR);
   assign stat.ignore = !auto_detect_ff || req_ff.is_remote || (req_ff.length_code < MIN_LENGTH);
   assign stat.hit = rd_vld_ff && (rd_data_ff.ident == req_ff.can_id);
   assign stat.scan_done = (idx_ff == fill_ff) && !rd_vld_ff;
   assign stat.full = (fill_ff == CW'(TABLE_ENTRIES));

   // Decision rule: a lead must strictly exceed the threshold
   assign le_lead = {1'b0, little_ff} - {1'b0, big_ff};
   assign be_lead = {1'b0, big_ff} - {1'b0, little_ff};
   always_comb begin
      if (!le_lead[TOTAL_W] && (le_lead[TOTAL_W-1:0] > TOTAL_W'(threshold_ff))) begin
         order_dec = ORDER_LITTLE;
      end else if (!be_lead[TOTAL_W] && (be_lead[TOTAL_W-1:0] > TOTAL_W'(threshold_ff))) begin
         order_dec = ORDER_BIG;
      end else begin
         order_dec = order_ff;
      end
   end
   assign fresh = (order_dec != order_ff) && (order_dec != ORDER_NONE);

   // Next values
   always_comb begin
      req_in = req_ff;
      auto_detect_in = auto_detect_ff;
      threshold_in = threshold_ff;
      fill_in = fill_ff;
      idx_in = idx_ff;
      rd_vld_in = rd_vld_ff;
      rd_idx_in = rd_idx_ff;
      slot_in = slot_ff;
      old_word_in = old_word_ff;
      be_diff_in = be_diff_ff;
      le_diff_in = le_diff_ff;
      vote_in = vote_ff;
      little_in = little_ff;
      big_in = big_ff;
      order_in = order_ff;

      // Control register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_AUTO_DETECT:    auto_detect_in = csr_data[0];
            CSR_LEAD_THRESHOLD: threshold_in = csr_data;
            default:            ;
         endcase
      end

      if (cmd.capture) begin
         req_in = req_data;
      end

      // Empty the table and reset detection
      if (cmd.clear) begin
         fill_in = '0;
         little_in = '0;
         big_in = '0;
         order_in = ORDER_NONE;
      end

      if (cmd.scan_init) begin
         idx_in = '0;
         rd_vld_in = 1'b0;
         vote_in = ORDER_NONE;
      end

      // Advance the scan pointer over the filled entries
      if (cmd.scan_step) begin
         rd_vld_in = (idx_ff < fill_ff);
         rd_idx_in = idx_ff[AW-1:0];
         if (idx_ff < fill_ff) begin
            idx_in = idx_ff + CW'(1);
         end
      end

      if (cmd.take_hit) begin
         slot_in = rd_idx_ff;
         old_word_in = rd_data_ff.word;
      end

      if (cmd.claim) begin
         fill_in = fill_ff + CW'(1);
      end

      if (cmd.diff) begin
         be_diff_in = abs_diff(new_word, old_word_ff);
         le_diff_in = abs_diff(swap_bytes(new_word), swap_bytes(old_word_ff));
      end

      // Smaller change wins the vote; totals saturate
      if (cmd.vote) begin
         if (le_diff_ff < be_diff_ff) begin
            vote_in = ORDER_LITTLE;
            if (little_ff != TOTAL_MAX) begin
               little_in = little_ff + TOTAL_W'(1);
            end
         end else if (be_diff_ff < le_diff_ff) begin
            vote_in = ORDER_BIG;
            if (big_ff != TOTAL_MAX) begin
               big_in = big_ff + TOTAL_W'(1);
            end
         end
      end

      if (cmd.decide) begin
         order_in = order_dec;
      end
   end

   // Result for this transaction
   always_comb begin
      rsp_valid_in = cmd.respond;
      rsp_in.status = cmd.status;
      rsp_in.vote = (cmd.status == STATUS_COMPARED) ? vote_ff : ORDER_NONE;
      if (cmd.decide) begin
         rsp_in.detected_order = order_dec;
      end else if (cmd.clear) begin
         rsp_in.detected_order = ORDER_NONE;
      end else begin
         rsp_in.detected_order = order_ff;
      end
      rsp_in.newly_detected = cmd.decide && fresh;
   end

   // Table write: claim a new entry or refresh the matched one
   assign wr_en = cmd.claim || cmd.diff;
   assign wr_addr = cmd.claim ? fill_ff[AW-1:0] : slot_ff;
   assign wr_entry = '{ident: req_ff.can_id, word: new_word};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_detect_ff <= AUTO_DETECT_RESET;
         threshold_ff <= LEAD_THRESHOLD_RESET;
         fill_ff <= '0;
         rd_vld_ff <= 1'b0;
         little_ff <= '0;
         big_ff <= '0;
         order_ff <= ORDER_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         auto_detect_ff <= auto_detect_in;
         threshold_ff <= threshold_in;
         fill_ff <= fill_in;
         rd_vld_ff <= rd_vld_in;
         little_ff <= little_in;
         big_ff <= big_in;
         order_ff <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      rd_idx_ff <= rd_idx_in;
      slot_ff <= slot_in;
      old_word_ff <= old_word_in;
      be_diff_ff <= be_diff_in;
      le_diff_ff <= le_diff_in;
      vote_ff <= vote_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/cbod_checker.sv =====
// ----------------------------------------------------------------------------
// cbod_checker
// Port-level checks on the detector's transaction sequencing and results.
// ----------------------------------------------------------------------------
module cbod_checker import cbod_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // An accepted transaction holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // A result is shown only once the block has gone idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // Results never come back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // A clear reports an undecided order and no vote
   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_CLEARED) |->
         (rsp_data.detected_order == ORDER_NONE) && (rsp_data.vote == ORDER_NONE)
         && !rsp_data.newly_detected)
      else $error("clear result carries order or vote");

   // Only a comparison votes, and a fresh decision names an order
   a_vote_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_data.vote == ORDER_NONE) || (rsp_data.status == STATUS_COMPARED))
         && (!rsp_data.newly_detected || (rsp_data.detected_order != ORDER_NONE)))
      else $error("inconsistent vote or detection flag");

endmodule

bind can_byte_order_detector cbod_checker u_cbod_checker (.*);

// ===== verif/tb_can_byte_order_detector.sv =====
// ----------------------------------------------------------------------------
// tb_can_byte_order_detector
// Self-checking bench for the CAN byte-order detector. A queue-fed driver
// issues frames and clears under random gaps and register settings. A monitor
// predicts each result from a private copy of the table, vote totals and
// order, then compares every result field.
// ----------------------------------------------------------------------------
module tb_can_byte_order_detector;
   import cbod_pkg::*;

   localparam int unsigned ENTRIES = 128;
   localparam int unsigned POOL_SIZE = 4;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct {
      req_type req;
      bit      hold_drain;
      bit      calm;
   } pending_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_AUTO_DETECT;
   logic [7:0] csr_data = '0;

   can_byte_order_detector #(
      .TABLE_ENTRIES(ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Predicted detector state and register copy
   bit                 slot_used [ENTRIES];
   logic [IDENT_W-1:0] slot_ident [ENTRIES];
   logic [WORD_W-1:0]  slot_word [ENTRIES];
   logic [TOTAL_W-1:0] le_votes;
   logic [TOTAL_W-1:0] be_votes;
   logic [1:0]         order_seen;
   logic               auto_on;
   logic [7:0]         lead_thr;

   // Bench bookkeeping
   pending_item_type   pending_q [$];
   rsp_type            expected_q [$];
   int                 issued = 0;
   int                 accepted = 0;
   int                 gap_left = 0;
   int                 idle_cycles = 0;
   int                 fault_count = 0;
   int                 status_seen [8];
   int                 decisions = 0;
   logic [IDENT_W-1:0] id_pool [POOL_SIZE];
   logic [15:0]        tally [POOL_SIZE];

   initial forever #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic void forget_table();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      le_votes = '0;
      be_votes = '0;
      order_seen = ORDER_NONE;
   endfunction

   function automatic rsp_type predict_frame(req_type r);
      rsp_type           res;
      int                hit;
      int                free_slot;
      logic [WORD_W-1:0] be_new;
      logic [WORD_W-1:0] be_old;
      logic [WORD_W-1:0] le_new;
      logic [WORD_W-1:0] le_old;
      logic [WORD_W-1:0] be_delta;
      logic [WORD_W-1:0] le_delta;
      logic [1:0]        prior;
      res = '0;
      hit = -1;
      free_slot = -1;
      if (r.func == FUNC_CLEAR) begin
         forget_table();
         res.status = STATUS_CLEARED;
         return res;
      end
      res.detected_order = order_seen;
      if (!auto_on || r.is_remote || r.length_code < MIN_LENGTH) begin
         res.status = STATUS_IGNORED;
         return res;
      end
      // first matching identifier wins
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && slot_used[i] && slot_ident[i] == r.can_id) hit = i;
      end
      be_new = {r.first_byte, r.second_byte};
      if (hit >= 0) begin
         be_old = slot_word[hit];
         le_new = {be_new[7:0], be_new[15:8]};
         le_old = {be_old[7:0], be_old[15:8]};
         be_delta = (be_new >= be_old) ? be_new - be_old : be_old - be_new;
         le_delta = (le_new >= le_old) ? le_new - le_old : le_old - le_new;
         if (le_delta < be_delta) begin
            res.vote = ORDER_LITTLE;
            if (le_votes != TOTAL_MAX) le_votes++;
         end else if (be_delta < le_delta) begin
            res.vote = ORDER_BIG;
            if (be_votes != TOTAL_MAX) be_votes++;
         end
         slot_word[hit] = be_new;
         res.status = STATUS_COMPARED;
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (free_slot < 0 && !slot_used[i]) free_slot = i;
         end
         if (free_slot < 0) begin
            res.status = STATUS_FULL;
            return res;
         end
         slot_used[free_slot] = 1'b1;
         slot_ident[free_slot] = r.can_id;
         slot_word[free_slot] = be_new;
         res.status = STATUS_FIRST;
      end
      // decision rule runs on first samples too
      prior = order_seen;
      if (le_votes > be_votes && le_votes - be_votes > TOTAL_W'(lead_thr)) begin
         order_seen = ORDER_LITTLE;
      end else if (be_votes > le_votes && be_votes - le_votes > TOTAL_W'(lead_thr)) begin
         order_seen = ORDER_BIG;
      end
      res.detected_order = order_seen;
      res.newly_detected = (order_seen != prior && order_seen != ORDER_NONE);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic req_type frame(logic [IDENT_W-1:0] id, logic [3:0] len,
                                     logic [7:0] b0, logic [7:0] b1);
      req_type r;
      r.func = FUNC_OBSERVE;
      r.can_id = id;
      r.is_remote = 1'b0;
      r.length_code = len;
      r.first_byte = b0;
      r.second_byte = b1;
      return r;
   endfunction

   function automatic void queue_item(req_type r, bit drain = 1'b0, bit calm = 1'b0);
      pending_item_type p;
      p.req = r;
      p.hold_drain = drain;
      p.calm = calm;
      pending_q.push_back(p);
   endfunction

   // Advance a per-identifier counter and lay it out in the leaning byte order
   function automatic req_type counted_frame(int k, logic [1:0] lean);
      logic [3:0] len;
      len = 4'($urandom_range(2, 15));
      tally[k] = tally[k] + 16'($urandom_range(1, 20));
      case (lean)
         ORDER_LITTLE: return frame(id_pool[k], len, tally[k][7:0], tally[k][15:8]);
         ORDER_BIG:    return frame(id_pool[k], len, tally[k][15:8], tally[k][7:0]);
         default:      return frame(id_pool[k], len, 8'($urandom), 8'($urandom));
      endcase
   endfunction

   function automatic req_type noise_item();
      req_type r;
      r.func = FUNC_OBSERVE;
      r.can_id = IDENT_W'($urandom);
      r.is_remote = 1'($urandom_range(0, 1));
      r.length_code = 4'($urandom_range(0, 15));
      r.first_byte = 8'($urandom);
      r.second_byte = 8'($urandom);
      return r;
   endfunction

   // Mostly well-formed streams on a few identifiers, some noise and clears
   task automatic run_mix(int count, logic [1:0] lean, bit calm);
      req_type r;
      int      pick;
      foreach (id_pool[k]) begin
         id_pool[k] = IDENT_W'($urandom);
         tally[k] = 16'($urandom);
      end
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            r = counted_frame($urandom_range(0, POOL_SIZE - 1), lean);
         end else if (pick < 85) begin
            r = frame(id_pool[$urandom_range(0, POOL_SIZE - 1)], 4'($urandom_range(2, 15)),
                      8'($urandom), 8'($urandom));
         end else if (pick < 98) begin
            r = noise_item();
         end else begin
            r = noise_item();
            r.func = FUNC_CLEAR;
         end
         queue_item(r, $urandom_range(0, 49) == 0, calm);
      end
   endtask

   // Wait until every issued transaction has come back
   task automatic settle();
      while (pending_q.size() != 0 || issued != accepted || expected_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Driver: present queued transactions, hold until taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      pending_item_type nxt;
      logic             start_n;
      req_type          data_n;
      start_n = start;
      data_n = req_data;
      if (!reset && !(start && accepted != issued)) begin
         start_n = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_q.size() != 0 &&
                      !(pending_q[0].hold_drain && expected_q.size() != 0)) begin
            nxt = pending_q.pop_front();
            start_n = 1'b1;
            data_n = nxt.req;
            issued++;
            if (!nxt.calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 3);
         end
      end
      start <= start_n;
      req_data <= data_n;
   end

   // ---------------------------------------------------------------------
   // Monitor: check results, predict on acceptance, track register writes
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      bit      moved;
      moved = 1'b0;
      if (reset) begin
         auto_on = AUTO_DETECT_RESET;
         lead_thr = LEAD_THRESHOLD_RESET;
         forget_table();
         idle_cycles = 0;
      end else begin
         // compare against the oldest expectation
         if (rsp_valid) begin
            moved = 1'b1;
            if (expected_q.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected result: status %0d vote %0d order %0d new %0b",
                           rsp_data.status, rsp_data.vote, rsp_data.detected_order,
                           rsp_data.newly_detected);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.vote !== want.vote ||
                   rsp_data.detected_order !== want.detected_order ||
                   rsp_data.newly_detected !== want.newly_detected) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $write("mismatch: expected status %0d vote %0d order %0d new %0b, ",
                            want.status, want.vote, want.detected_order,
                            want.newly_detected);
                     $display("got status %0d vote %0d order %0d new %0b",
                              rsp_data.status, rsp_data.vote,
                              rsp_data.detected_order, rsp_data.newly_detected);
                  end
               end
               status_seen[want.status]++;
               if (want.newly_detected) decisions++;
            end
         end
         if (start && !busy) begin
            moved = 1'b1;
            expected_q.push_back(predict_frame(req_data));
            accepted++;
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index)
               CSR_AUTO_DETECT:    auto_on = csr_data[0];
               CSR_LEAD_THRESHOLD: lead_thr = csr_data;
            endcase
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("tb_can_byte_order_detector NOT OK");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence of phases
   // ---------------------------------------------------------------------
   initial begin
      req_type r;
      logic [21:0] id_base;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset registers, lead threshold 12
      r = noise_item();
      r.func = FUNC_CLEAR;
      r.can_id = '1;
      queue_item(r);
      r = frame(29'h0ABCDEF, 4'd8, 8'h12, 8'h34);
      r.is_remote = 1'b1;
      queue_item(r);                                          // remote frame
      queue_item(frame(29'h0ABCDEF, 4'd0, 8'h12, 8'h34));    // too short
      queue_item(frame(29'h0ABCDEF, 4'd1, 8'h12, 8'h34));
      queue_item(frame('0, 4'd2, 8'h00, 8'h00));              // first sample, lowest id
      queue_item(frame('1, 4'd15, 8'hFF, 8'hFF));             // first sample, highest id
      queue_item(frame('0, 4'd8, 8'h01, 8'h00));              // little-endian vote
      queue_item(frame('0, 4'd9, 8'h01, 8'h01));              // big-endian vote
      queue_item(frame('0, 4'd8, 8'h01, 8'h01));              // tie, no change
      queue_item(frame('1, 4'd9, 8'h00, 8'h00));              // tie, full swing
      queue_item(frame('1, 4'd8, 8'hFF, 8'h00));              // little-endian vote
      queue_item(frame(29'h15555555, 4'd3, 8'hA5, 8'h5A));
      queue_item(frame(29'h0AAAAAAA, 4'd8, 8'h5A, 8'hA5));
      queue_item(frame(29'h15555555, 4'd3, 8'hA5, 8'h5B));
      r = '0;
      r.func = FUNC_CLEAR;
      queue_item(r, 1'b1);                                     // clear after a pause
      queue_item(frame('0, 4'd2, 8'h01, 8'h01));              // table empty again
      settle();

      // default threshold: a little-endian stream, then a big-endian one
      run_mix(100, ORDER_LITTLE, 1'b0);
      run_mix(100, ORDER_BIG, 1'b0);
      settle();

      // zero threshold: any lead decides, random payloads flip the order
      write_csr(CSR_LEAD_THRESHOLD, 8'd0);
      run_mix(150, ORDER_NONE, 1'b0);
      settle();

      // widest threshold: fill every table entry, then overflow it
      write_csr(CSR_LEAD_THRESHOLD, 8'd255);
      write_csr(CSR_AUTO_DETECT, {7'($urandom), 1'b1});
      r = noise_item();
      r.func = FUNC_CLEAR;
      queue_item(r, 1'b1);
      id_base = 22'($urandom);
      for (int i = 0; i < ENTRIES; i++)
         queue_item(frame({id_base + 22'(i), 7'(i)}, 4'($urandom_range(2, 15)),
                          8'($urandom), 8'($urandom)));
      for (int i = 0; i < 3; i++)
         queue_item(frame({id_base, 7'(i)} ^ 29'h1FFFFF80, 4'd8, 8'($urandom),
                          8'($urandom)),
                    i == 0);
      for (int i = 0; i < 8; i++) begin
         int k;
         k = $urandom_range(0, ENTRIES - 1);
         queue_item(frame({id_base + 22'(k), 7'(k)}, 4'd8, 8'($urandom), 8'($urandom)));
      end
      r = noise_item();
      r.func = FUNC_CLEAR;
      queue_item(r);
      queue_item(frame('1, 4'd8, 8'h00, 8'hFF), 1'b1);
      settle();

      // detection off: frames pass untouched, clears still act
      write_csr(CSR_AUTO_DETECT, {7'($urandom), 1'b0});
      write_csr(CSR_LEAD_THRESHOLD, 8'($urandom_range(1, 254)));
      run_mix(60, ORDER_LITTLE, 1'b0);
      settle();

      // detection back on, small threshold; the tail runs without gaps
      write_csr(CSR_AUTO_DETECT, {7'($urandom), 1'b1});
      write_csr(CSR_LEAD_THRESHOLD, 8'($urandom_range(1, 20)));
      run_mix(220, ORDER_LITTLE, 1'b0);
      run_mix(150, ORDER_BIG, 1'b1);
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_q.size() != 0) begin
         fault_count += expected_q.size();
         $display("%0d results never arrived", expected_q.size());
      end
      $write("covered %0d transactions: %0d ignored, %0d first, ",
             accepted, status_seen[STATUS_IGNORED], status_seen[STATUS_FIRST]);
      $display("%0d compared, %0d full, %0d cleared",
               status_seen[STATUS_COMPARED], status_seen[STATUS_FULL],
               status_seen[STATUS_CLEARED]);
      $display("order decisions reported: %0d, mismatches: %0d", decisions, fault_count);
      if (fault_count == 0) begin
         $display("tb_can_byte_order_detector OK");
      end else begin
         $display("tb_can_byte_order_detector NOT OK");
      end
      $finish;
   end

endmodule

// ===== can_byte_order_detector.f =====
rtl/cbod_pkg.sv
rtl/cbod_ctrl.sv
rtl/cbod_datapath.sv
rtl/can_byte_order_detector.sv
rtl/cbod_checker.sv
verif/tb_can_byte_order_detector.sv
